[design/ps2s1_pkg.sv]
// ----------------------------------------------------------------------------
// ps2s1_pkg
// types and code constants shared by the ps/2 set-1 scancode decoder
// ----------------------------------------------------------------------------
package ps2s1_pkg;

  // prefix tracking state
  typedef enum logic [1:0] {
    PFX_IDLE = 2'd0,
    PFX_E0   = 2'd1,
    PFX_E1_A = 2'd2,
    PFX_E1_B = 2'd3
  } pfx_state_t;

  // prefix and special bytes
  localparam logic [7:0] CODE_E0          = 8'hE0;
  localparam logic [7:0] CODE_E1          = 8'hE1;
  localparam logic [7:0] CODE_FAKE_SHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] CODE_FAKE_SHIFT_BREAK = 8'hAA;
  localparam int unsigned BREAK_BIT      = 7;

  // make codes with a role in the decoder
  localparam logic [6:0] KEYC_LEFT_CTRL = 7'h1D;
  localparam logic [6:0] KEYC_LEFT_ALT  = 7'h38;
  localparam logic [6:0] KEYC_NUM_LOCK  = 7'h45;
  localparam logic [6:0] KEYC_CAPS_LOCK = 7'h3A;
  localparam logic [6:0] KEYC_DELETE    = 7'h53;

  // one decoded key event
  typedef struct packed {
    logic       reboot_request;
    logic [2:0] led_value;
    logic       caps_lock_on;
    logic       num_lock_on;
    logic       is_press;
    logic [6:0] key_code;
    logic       is_extended;
  } key_event_t;

endpackage

[design/ps2s1_decode.sv]
// ----------------------------------------------------------------------------
// ps2s1_decode
// prefix state machine, lock flags and modifier tracking for one byte a cycle while take is high
// ----------------------------------------------------------------------------
module ps2s1_decode
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,        // byte is consumed this cycle
  input  logic [7:0] scan_byte,
  output logic       emit,        // byte completes a key code
  output key_event_t ev
);

  pfx_state_t pfx_r, pfx_nxt;
  logic       num_lock_r, num_lock_nxt;
  logic       caps_lock_r, caps_lock_nxt;
  logic       lctrl_r, lctrl_nxt;
  logic       lalt_r, lalt_nxt;

  logic       ext;
  logic       press;
  logic [6:0] code;
  logic       is_fake_shift;

  assign code          = scan_byte[6:0];
  assign press         = ~scan_byte[BREAK_BIT];
  assign is_fake_shift = (scan_byte == CODE_FAKE_SHIFT_MAKE) ||
                         (scan_byte == CODE_FAKE_SHIFT_BREAK);

  // next prefix state
  always_comb begin
    pfx_nxt = pfx_r;
    unique case (pfx_r)
      PFX_IDLE: begin
        if (scan_byte == CODE_E0) begin
          pfx_nxt = PFX_E0;
        end else if (scan_byte == CODE_E1) begin
          pfx_nxt = PFX_E1_A;
        end else begin
          pfx_nxt = PFX_IDLE;
        end
      end
      PFX_E0:   pfx_nxt = PFX_IDLE;
      PFX_E1_A: pfx_nxt = PFX_E1_B;
      PFX_E1_B: pfx_nxt = PFX_IDLE;
      default:  pfx_nxt = PFX_IDLE;
    endcase
  end

  // outputs of the prefix state machine
  always_comb begin
    emit = 1'b0;
    ext  = 1'b0;
    unique case (pfx_r)
      PFX_IDLE: emit = (scan_byte != CODE_E0) && (scan_byte != CODE_E1);
      PFX_E0: begin
        emit = ~is_fake_shift;
        ext  = 1'b1;
      end
      PFX_E1_A: emit = 1'b0;
      PFX_E1_B: emit = 1'b0;
      default:  emit = 1'b0;
    endcase
  end

  // only left ctrl and left alt of the key-down table are ever read back,
  // so the rest of the table is not kept
  always_comb begin
    num_lock_nxt  = num_lock_r;
    caps_lock_nxt = caps_lock_r;
    lctrl_nxt     = lctrl_r;
    lalt_nxt      = lalt_r;
    if (emit && !ext) begin
      if (code == KEYC_LEFT_CTRL) lctrl_nxt = press;
      if (code == KEYC_LEFT_ALT)  lalt_nxt  = press;
      if (press && code == KEYC_NUM_LOCK)  num_lock_nxt  = ~num_lock_r;
      if (press && code == KEYC_CAPS_LOCK) caps_lock_nxt = ~caps_lock_r;
    end
  end

  always_comb begin
    ev.is_extended    = ext;
    ev.key_code       = code;
    ev.is_press       = press;
    ev.num_lock_on    = num_lock_nxt;
    ev.caps_lock_on   = caps_lock_nxt;
    ev.led_value      = {caps_lock_nxt, num_lock_nxt, 1'b0};
    ev.reboot_request = ext && press && (code == KEYC_DELETE) && lctrl_r && lalt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_r       <= PFX_IDLE;
      num_lock_r  <= 1'b1;
      caps_lock_r <= 1'b0;
      lctrl_r     <= 1'b0;
      lalt_r      <= 1'b0;
    end else if (take) begin
      pfx_r       <= pfx_nxt;
      num_lock_r  <= num_lock_nxt;
      caps_lock_r <= caps_lock_nxt;
      lctrl_r     <= lctrl_nxt;
      lalt_r      <= lalt_nxt;
    end
  end

endmodule

[design/ps2_set1_scancode_decoder.sv]
// ----------------------------------------------------------------------------
// ps2_set1_scancode_decoder
// ps/2 scan code set 1 byte stream to key event stream
// ----------------------------------------------------------------------------
// path: a byte lands in the input register at the transfer, then is decoded
//   into the result register, which drives out_tvalid
// throughput: one byte per cycle while the output is not stalled, set by the
//   single decode pass between the two registers; prefix and dropped bytes leave no result
// reset: synchronous on rst_n low; prefix state idle, num lock on, caps lock
//   off, no key held, both pipeline registers empty
// ----------------------------------------------------------------------------
module ps2_set1_scancode_decoder
  import ps2s1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_byte
  // key event stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] is_extended, [7:1] key_code, [8] is_press,
                                  // [9] num_lock_on, [10] caps_lock_on,
                                  // [13:11] led_value, [14] reboot_request, [15] zero
);

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  key_event_t out_event_r;

  logic       emit;
  key_event_t ev;
  logic       out_free;   // result register can take a new event
  logic       consume;    // byte in the input register is used up
  logic       in_xfer;

  assign out_free = !out_valid_r || out_tready;
  // a byte that makes no event never waits on the output side
  assign consume  = in_valid_r && (!emit || out_free);
  assign in_tready = !in_valid_r || consume;
  assign in_xfer  = in_tvalid && in_tready;

  assign in_valid_nxt  = (in_valid_r && !consume) || in_xfer;
  assign out_valid_nxt = (out_valid_r && !out_tready) || (consume && emit);

  ps2s1_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (consume),
    .scan_byte (in_byte_r),
    .emit      (emit),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_tdata;
    end
    if (consume && emit) begin
      out_event_r <= ev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_event_r};

endmodule

[design/ps2s1_checker.sv]
// ----------------------------------------------------------------------------
// ps2s1_checker
// port-level checks on the ps/2 set-1 scancode decoder
// ----------------------------------------------------------------------------
module ps2s1_checker
  import ps2s1_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled event changed");

  // led bits mirror the lock flags, pad bit zero
  a_led_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11] == 1'b0) && (out_tdata[12] == out_tdata[9]) &&
                   (out_tdata[13] == out_tdata[10]) && (out_tdata[15] == 1'b0))
    else $error("led value does not match lock flags");

  // reboot only on an extended delete press
  a_reboot_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |->
      out_tdata[0] && out_tdata[8] && (out_tdata[7:1] == KEYC_DELETE))
    else $error("reboot request on wrong key");

  // fake shift after e0 is never reported
  a_no_fake_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[7:1] != CODE_FAKE_SHIFT_MAKE[6:0])
    else $error("extended fake shift reported");

endmodule

bind ps2_set1_scancode_decoder ps2s1_checker u_ps2s1_checker (.*);

[tb/ps2_set1_scancode_decoder_tb.sv]
// ----------------------------------------------------------------------------
// ps2_set1_scancode_decoder_tb
// self-checking bench for the ps/2 set-1 scancode decoder: a byte stream with
// prefixes, pause sequences, fake shifts, lock keys and ctrl+alt+del is fed
// in, a local decoder model predicts each key event, and every event on the
// output stream is compared field by field, under random gaps and stalls
// ----------------------------------------------------------------------------
module ps2_set1_scancode_decoder_tb
  import ps2s1_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 300;
  localparam int SETTLE      = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] scan_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;            // [0] is_extended, [7:1] key_code, [8] is_press,
                                     // [9] num_lock_on, [10] caps_lock_on,
                                     // [13:11] led_value, [14] reboot_request, [15] zero

  ps2_set1_scancode_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // decoder model state, mirrors the block after each accepted byte
  pfx_state_t   mdl_prefix    = PFX_IDLE;
  logic [255:0] keys_down     = '0;
  logic         num_lock_mdl  = 1'b1;
  logic         caps_lock_mdl = 1'b0;

  key_event_t   pending_events[$];   // predicted events not yet seen on the output
  int           mismatch_count = 0;
  int           bytes_sent     = 0;
  int           cycle_count    = 0;

  // knobs shared by the test tasks and the two stream processes
  bit           source_gaps    = 1'b0;
  int           sink_stall_pct = 0;
  bit           long_stall_req = 1'b0;

  // ---------------------------------------------------------------------------
  // decoder model: returns 1 when the byte completes a key code
  // ---------------------------------------------------------------------------
  function automatic bit decode_scan_byte(input logic [7:0] b, output key_event_t ev);
    logic       ext;
    logic       press;
    logic       reboot;
    logic [6:0] code;
    code  = b[6:0];
    press = ~b[BREAK_BIT];
    ev    = '0;
    case (mdl_prefix)
      PFX_E1_B: begin
        mdl_prefix = PFX_IDLE;
        return 1'b0;
      end
      PFX_E1_A: begin
        mdl_prefix = PFX_E1_B;
        return 1'b0;
      end
      PFX_E0: begin
        mdl_prefix = PFX_IDLE;
        // fake shift around extended keys carries no event
        if (b == CODE_FAKE_SHIFT_MAKE || b == CODE_FAKE_SHIFT_BREAK) return 1'b0;
        ext = 1'b1;
      end
      default: begin
        if (b == CODE_E0) begin
          mdl_prefix = PFX_E0;
          return 1'b0;
        end
        if (b == CODE_E1) begin
          mdl_prefix = PFX_E1_A;
          return 1'b0;
        end
        ext = 1'b0;
      end
    endcase

    keys_down[{ext, code}] = press;
    reboot = 1'b0;
    if (press) begin
      if (ext) begin
        if (code == KEYC_DELETE && keys_down[{1'b0, KEYC_LEFT_CTRL}] &&
            keys_down[{1'b0, KEYC_LEFT_ALT}])
          reboot = 1'b1;
      end else if (code == KEYC_NUM_LOCK) begin
        num_lock_mdl = ~num_lock_mdl;
      end else if (code == KEYC_CAPS_LOCK) begin
        caps_lock_mdl = ~caps_lock_mdl;
      end
    end

    ev.is_extended    = ext;
    ev.key_code       = code;
    ev.is_press       = press;
    ev.num_lock_on    = num_lock_mdl;
    ev.caps_lock_on   = caps_lock_mdl;
    ev.led_value      = {caps_lock_mdl, num_lock_mdl, 1'b0};
    ev.reboot_request = reboot;
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // any byte that is not a prefix, so it forms a whole key code on its own
  function automatic logic [7:0] plain_code_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CODE_E0 || b == CODE_E1);
    return b;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // source side: offer one byte, predict on the transfer, then maybe idle
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    key_event_t ev;
    int         gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (decode_scan_byte(b, ev)) pending_events.push_back(ev);
    gap = source_gaps ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // source goes quiet until every predicted event has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // sink side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : key_event_sink
    int stall;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
        stall = gap_len();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard: each output transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score_key_events
    key_event_t exp_ev;
    key_event_t act_ev;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $error("key event with nothing predicted: out_tdata %04h", out_tdata);
        mismatch_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        act_ev = out_tdata[14:0];
        check_field("is_extended", 32'(exp_ev.is_extended), 32'(act_ev.is_extended));
        check_field("key_code", 32'(exp_ev.key_code), 32'(act_ev.key_code));
        check_field("is_press", 32'(exp_ev.is_press), 32'(act_ev.is_press));
        check_field("num_lock_on", 32'(exp_ev.num_lock_on), 32'(act_ev.num_lock_on));
        check_field("caps_lock_on", 32'(exp_ev.caps_lock_on), 32'(act_ev.caps_lock_on));
        check_field("led_value", 32'(exp_ev.led_value), 32'(act_ev.led_value));
        check_field("reboot_request", 32'(exp_ev.reboot_request),
                    32'(act_ev.reboot_request));
        check_field("pad bit", 32'd0, 32'(out_tdata[15]));
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ps2_set1_scancode_decoder_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // field extremes, lock keys, every prefix case and ctrl+alt+del
  task automatic test_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'hFF,
            {1'b0, KEYC_NUM_LOCK}, {1'b1, KEYC_NUM_LOCK},        // num lock toggles off
            {1'b0, KEYC_CAPS_LOCK}, {1'b1, KEYC_CAPS_LOCK},      // caps lock toggles on
            CODE_E0, {1'b0, KEYC_NUM_LOCK},                      // extended form, no toggle
            CODE_E0, CODE_FAKE_SHIFT_MAKE,                       // fake shift dropped
            CODE_E0, CODE_FAKE_SHIFT_BREAK,
            CODE_E0, CODE_E0,                                    // prefix after E0 is a code
            CODE_E0, CODE_E1,
            CODE_E1, {1'b0, KEYC_LEFT_CTRL}, {1'b0, KEYC_NUM_LOCK},  // pause, both dropped
            {1'b0, KEYC_LEFT_CTRL}, {1'b0, KEYC_LEFT_ALT},
            CODE_E0, {1'b0, KEYC_DELETE},                        // reboot request
            {1'b1, KEYC_LEFT_CTRL}, {1'b1, KEYC_LEFT_ALT}};
    source_gaps    = 1'b0;
    sink_stall_pct = 0;
    foreach (seq[i]) send_byte(seq[i]);
    wait_drained();
  endtask

  // sink holds off for a long stretch while the source keeps offering
  task automatic test_backpressure();
    source_gaps    = 1'b0;
    sink_stall_pct = 0;
    long_stall_req = 1'b1;
    repeat (40) send_byte(plain_code_byte());
    wait_drained();
  endtask

  // source pauses mid-stream until the output has caught up
  task automatic test_drain_pause();
    source_gaps    = 1'b1;
    sink_stall_pct = 30;
    repeat (15) send_byte(plain_code_byte());
    wait_drained();
    repeat (15) send_byte(plain_code_byte());
    wait_drained();
  endtask

  // mostly well-formed key sequences with random content, some noise
  task automatic test_random_stream(input int n_bytes, input bit with_idle);
    int         first;
    int         kind;
    logic       rel;
    logic [7:0] b;
    source_gaps    = with_idle;
    sink_stall_pct = with_idle ? 30 : 0;
    first          = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      kind = $urandom_range(99);
      rel  = 1'($urandom_range(1));
      if (kind < 40) begin
        send_byte(plain_code_byte());
      end else if (kind < 58) begin
        // extended key, now and then the fake shift
        send_byte(CODE_E0);
        if ($urandom_range(9) == 0)
          send_byte(rel ? CODE_FAKE_SHIFT_BREAK : CODE_FAKE_SHIFT_MAKE);
        else
          send_byte(8'($urandom_range(255)));
      end else if (kind < 65) begin
        // pause sequence with arbitrary trailing bytes
        send_byte(CODE_E1);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
      end else if (kind < 76) begin
        b = {rel, ($urandom_range(1) ? KEYC_NUM_LOCK : KEYC_CAPS_LOCK)};
        send_byte(b);
      end else if (kind < 86) begin
        // ctrl+alt+del, sometimes leaving the modifiers held
        send_byte({1'b0, KEYC_LEFT_CTRL});
        send_byte({1'b0, KEYC_LEFT_ALT});
        send_byte(CODE_E0);
        send_byte({1'b0, KEYC_DELETE});
        send_byte(CODE_E0);
        send_byte({1'b1, KEYC_DELETE});
        if ($urandom_range(1)) send_byte({1'b1, KEYC_LEFT_CTRL});
        if ($urandom_range(1)) send_byte({1'b1, KEYC_LEFT_ALT});
      end else if (kind < 92) begin
        // extended delete alone, reboot only if both modifiers still held
        send_byte(CODE_E0);
        send_byte({rel, KEYC_DELETE});
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_stream(120, 1'b0);
    test_random_stream(330, 1'b1);

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("ps2_set1_scancode_decoder_tb passed");
    end else begin
      $display("ps2_set1_scancode_decoder_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
design/ps2s1_pkg.sv
design/ps2s1_decode.sv
design/ps2_set1_scancode_decoder.sv
design/ps2s1_checker.sv
tb/ps2_set1_scancode_decoder_tb.sv
